>>> sv/mrw_pkg.sv
// Shared definitions for the Miller-Rabin witness test block.
// Holds the default working width, the sequencer state type and the result beat type.
// No dependencies.
package mrw_pkg;

  localparam int unsigned MRW_WIDTH = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_REDUCE,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_SQ_INIT,
    ST_SQUARE,
    ST_FINISH
  } mrw_state_e;

  typedef struct packed {
    logic valid;
    logic composite;
  } mrw_res_t;

endpackage

>>> sv/mrw_modmul.sv
// Bit-serial modular multiplier: (a * b) mod n by double-and-add, one multiplier bit per cycle.
// Operand a and modulus n are read live and must hold for the whole product; b is shifted in.
// Depends on mrw_pkg for the default width.
module mrw_modmul #(
  parameter int unsigned W = mrw_pkg::MRW_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);
  localparam int unsigned EW = W + 3;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  mplr_q;
  logic [W-1:0]  acc_d;
  logic [EW-1:0] addend;
  logic [EW-1:0] sum;
  logic [EW-1:0] dif1;
  logic [EW-1:0] dif2;

  // Double the accumulator, add a when the multiplier bit is set, reduce below n.
  // The sum stays below 3n, so subtracting n or 2n is enough.
  assign addend = mplr_q[W-1] ? {3'b000, a_i} : '0;
  assign sum    = {2'b00, acc_q, 1'b0} + addend;
  assign dif1   = sum - {3'b000, n_i};
  assign dif2   = sum - {2'b00, n_i, 1'b0};

  always_comb begin
    if (!dif2[EW-1]) begin
      acc_d = dif2[W-1:0];
    end else if (!dif1[EW-1]) begin
      acc_d = dif1[W-1:0];
    end else begin
      acc_d = sum[W-1:0];
    end
  end

  // Count the multiplier bits and flag the finished product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Load the multiplier, then shift it out MSB first while the accumulator advances.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      mplr_q <= b_i;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      mplr_q <= {mplr_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> sv/mrw_seq.sv
// Sequencer for one witness test: trivial cases, n-1 = u * 2^t, base reduction,
// square-and-multiply for b^u, then t squarings with the nontrivial-root check.
// Depends on mrw_pkg and mrw_modmul.
module mrw_seq #(
  parameter int unsigned W = mrw_pkg::MRW_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     cand_i,
  input  logic [W-1:0]     base_i,
  output logic             ready_o,
  output mrw_pkg::mrw_res_t res_o,
  input  logic             res_ready_i
);

  import mrw_pkg::*;

  localparam int unsigned TW = $clog2(W);

  mrw_state_e    state_q;
  mrw_state_e    state_d;
  logic          mm_start_q;
  logic          mm_start_d;
  logic          mm_done;
  logic [W-1:0]  mm_prod;
  logic [W-1:0]  mm_a;
  logic [W-1:0]  mm_b;

  logic [W-1:0]  n_q;
  logic [W-1:0]  b_q;
  logic [W-1:0]  nm1_q;
  logic [W-1:0]  u_q;
  logic [TW-1:0] t_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  sq_q;
  logic [W-1:0]  prev_q;
  logic          comp_q;

  logic          cand_is_two;
  logic          trivial;
  logic          u_rest;
  logic          witness;

  assign cand_is_two = (cand_i == W'(2));
  assign trivial     = cand_is_two || !cand_i[0] || (cand_i == W'(1));
  assign u_rest      = (u_q[W-1:1] != '0);
  assign witness     = (mm_prod == W'(1)) && (prev_q != W'(1)) && (prev_q != nm1_q);

  // Select the multiplier operands for the current step.
  always_comb begin
    case (state_q)
      ST_REDUCE: begin
        mm_a = W'(1);
        mm_b = b_q;
      end
      ST_POW_MUL: begin
        mm_a = acc_q;
        mm_b = sq_q;
      end
      ST_POW_SQ: begin
        mm_a = sq_q;
        mm_b = sq_q;
      end
      default: begin
        mm_a = acc_q;
        mm_b = acc_q;
      end
    endcase
  end

  mrw_modmul #(
    .W(W)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start_q),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .n_i    (n_q),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = trivial ? ST_FINISH : ST_FACTOR;
        end
      end
      ST_FACTOR: begin
        if (u_q[0]) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE, ST_POW_MUL: begin
        if (mm_done) begin
          state_d = u_rest ? ST_POW_SQ : ST_SQ_INIT;
        end
      end
      ST_POW_SQ: begin
        if (mm_done && u_q[0]) begin
          state_d = ST_POW_MUL;
        end
      end
      ST_SQ_INIT: begin
        state_d = (t_q == '0) ? ST_FINISH : ST_SQUARE;
      end
      ST_SQUARE: begin
        if (mm_done && (witness || (t_q == TW'(1)))) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: multiplier launches and handshake flags.
  always_comb begin
    mm_start_d = 1'b0;
    case (state_q)
      ST_FACTOR:             mm_start_d = u_q[0];
      ST_REDUCE, ST_POW_MUL: mm_start_d = mm_done && u_rest;
      ST_POW_SQ:             mm_start_d = mm_done;
      ST_SQ_INIT:            mm_start_d = (t_q != '0);
      ST_SQUARE:             mm_start_d = mm_done && !witness && (t_q != TW'(1));
      default:               mm_start_d = 1'b0;
    endcase
  end

  assign ready_o         = (state_q == ST_IDLE);
  assign res_o.valid     = (state_q == ST_FINISH);
  assign res_o.composite = comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mm_start_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mm_start_q <= mm_start_d;
    end
  end

  // Working registers, advanced by state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_q    <= cand_i;
          b_q    <= base_i;
          nm1_q  <= cand_i - W'(1);
          u_q    <= cand_i - W'(1);
          t_q    <= '0;
          comp_q <= !cand_is_two;
        end
      end
      ST_FACTOR: begin
        // Strip factors of two from n-1.
        if (!u_q[0]) begin
          u_q <= {1'b0, u_q[W-1:1]};
          t_q <= t_q + TW'(1);
        end
      end
      ST_REDUCE: begin
        // b mod n doubles as the first product, since u is odd.
        if (mm_done) begin
          sq_q  <= mm_prod;
          acc_q <= mm_prod;
          u_q   <= {1'b0, u_q[W-1:1]};
        end
      end
      ST_POW_MUL: begin
        if (mm_done) begin
          acc_q <= mm_prod;
          u_q   <= {1'b0, u_q[W-1:1]};
        end
      end
      ST_POW_SQ: begin
        if (mm_done) begin
          sq_q <= mm_prod;
          if (!u_q[0]) begin
            u_q <= {1'b0, u_q[W-1:1]};
          end
        end
      end
      ST_SQ_INIT: begin
        comp_q <= (acc_q != W'(1));
        prev_q <= acc_q;
      end
      ST_SQUARE: begin
        if (mm_done) begin
          acc_q  <= mm_prod;
          prev_q <= mm_prod;
          t_q    <= t_q - TW'(1);
          comp_q <= witness || (mm_prod != W'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/miller_rabin_witness_test.sv
// Miller-Rabin witness test: one candidate and one base per beat, one composite flag out.
// Candidates 1, 2 and even values pass from the sequencer's finish state to the output register.
// Odd candidates run their modular products through the bit-serial multiplier.
// One item at a time: the next beat is taken once the result moves to the output register.
// Reset clears the sequencer and the output valid; the block is ready right after reset.
module miller_rabin_witness_test #(
  parameter int unsigned WIDTH = mrw_pkg::MRW_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] candidate_i,
  input  logic [WIDTH-1:0] base_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             composite_o
);

  import mrw_pkg::*;

  mrw_res_t res;
  logic     seq_ready;
  logic     res_ready;
  logic     out_valid_q;
  logic     composite_q;

  assign in_ready_o = seq_ready;
  assign res_ready  = !out_valid_q || out_ready_i;

  mrw_seq #(
    .W(WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && seq_ready),
    .cand_i     (candidate_i),
    .base_i     (base_i),
    .ready_o    (seq_ready),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // Output register: load a finished result when the slot is free or draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      composite_q <= res.composite;
    end
  end

  assign out_valid_o = out_valid_q;
  assign composite_o = composite_q;

endmodule

>>> sv/mrw_checker.sv
// Port-level checks for the Miller-Rabin witness test, bound to the top level.
// Depends on miller_rabin_witness_test and mrw_pkg for the default width.
module mrw_checker #(
  parameter int unsigned WIDTH = mrw_pkg::MRW_WIDTH
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [WIDTH-1:0] candidate_i,
  input logic [WIDTH-1:0] base_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             composite_o
);

  // Hold a stalled result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(composite_o))
    else $error("result beat changed while stalled");

  // Drop ready for the item just taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // Trivial candidates answer through the finish state and the output register when the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (base_i == base_i) &&
    ((candidate_i == WIDTH'(2)) || !candidate_i[0] || (candidate_i == WIDTH'(1)))
    |-> ##2 (out_valid_o && (composite_o == ($past(candidate_i, 2) != WIDTH'(2)))))
    else $error("wrong or late answer for a trivial candidate");

endmodule

bind miller_rabin_witness_test mrw_checker #(.WIDTH(WIDTH)) u_mrw_checker (.*);
